/* sv/multilevel_feedback_queue_scheduler_top_assert.svh */
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Clocked assertion wrappers shared by the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Check a condition on every clock edge outside reset.
`define MFQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an event is followed by a condition in the next cycle.
`define MFQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mfqs_pkg.sv */
// ----------------------------------------------------------------------------
// Scheduler package
// Sizes, codes, types and helper functions of the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfqs_pkg;

  // Sizing
  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 16;
  localparam int LEVEL_COUNT  = 3;
  localparam int BOTTOM_LEVEL = 2;
  localparam int POS_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH    = LEVEL_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);

  // Port field widths
  localparam int OP_W         = 2;
  localparam int TASK_FIELD_W = 16;
  localparam int STATUS_W     = 2;
  localparam int LEVEL_W      = 2;
  localparam int SLICE_W      = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 4;

  typedef logic [TASK_ID_BITS-1:0] task_id_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [LEVEL_W-1:0]      level_t;
  typedef logic [SLICE_W-1:0]      slice_t;
  typedef logic [OP_W-1:0]         op_t;
  typedef logic [STATUS_W-1:0]     status_t;

  // Operation codes
  localparam op_t OP_ADD        = 2'd0;
  localparam op_t OP_DISPATCH   = 2'd1;
  localparam op_t OP_SLICE_DONE = 2'd2;

  // Result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NO_GRANT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL0_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL1_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL2_LIMIT = 2'd2;

  // Slice limits after reset, one per level
  localparam slice_t LIMIT_RESET [LEVEL_COUNT] = '{4'd1, 4'd2, 4'd4};

  // Controller to datapath commands
  typedef struct packed {
    logic latch;    // capture the accepted item
    logic rd_en;    // read the head of the chosen FIFO
    logic commit;   // update state and load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_needed;  // dispatch must pop a FIFO head first
    logic out_free;    // result register can take a new result
  } dp_stat_t;

  // Flat store address of a FIFO slot
  function automatic addr_t slot_addr(level_t lv, pos_t pos);
    logic [ADDR_W:0] a;
    a = (ADDR_W+1)'(lv) * (ADDR_W+1)'(QUEUE_DEPTH) + (ADDR_W+1)'(pos);
    return a[ADDR_W-1:0];
  endfunction

  // Tail position of a circular FIFO
  function automatic pos_t tail_pos(pos_t head, cnt_t count);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[POS_W-1:0];
  endfunction

  // Advance a head pointer with wrap
  function automatic pos_t next_pos(pos_t p);
    return (p == POS_W'(QUEUE_DEPTH - 1)) ? '0 : pos_t'(p + 1'b1);
  endfunction

endpackage

/* sv/mfqs_ifs.sv */
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel
interface mfqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [mfqs_pkg::OP_W-1:0]           operation;
  logic [mfqs_pkg::TASK_FIELD_W-1:0]   task_id;
  logic                                still_alive;

  modport source (output valid, operation, task_id, still_alive, input ready);
  modport sink   (input valid, operation, task_id, still_alive, output ready);
endinterface

// Result item channel
interface mfqs_out_if;
  logic                                valid;
  logic                                ready;
  logic [mfqs_pkg::STATUS_W-1:0]       status;
  logic [mfqs_pkg::TASK_FIELD_W-1:0]   grant_task;
  logic [mfqs_pkg::LEVEL_W-1:0]        grant_level;
  logic [mfqs_pkg::SLICE_W-1:0]        grant_slice;
  logic                                demoted;
  logic                                removed;

  modport source (output valid, status, grant_task, grant_level, grant_slice,
                  demoted, removed, input ready);
  modport sink   (input valid, status, grant_task, grant_level, grant_slice,
                  demoted, removed, output ready);
endinterface

// Register write channel
interface mfqs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mfqs_pkg::CFG_INDEX_W-1:0]    index;
  logic [mfqs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/mfqs_dp.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task store, per-level FIFO pointers, held slots, slice counters, grant
// tracking, slice limit registers and the result register.
// ----------------------------------------------------------------------------
module mfqs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mfqs_pkg::dp_cmd_t                   cmd,
  output mfqs_pkg::dp_stat_t                  stat,
  input  logic [mfqs_pkg::OP_W-1:0]           in_operation,
  input  logic [mfqs_pkg::TASK_FIELD_W-1:0]   in_task_id,
  input  logic                                in_still_alive,
  input  logic                                cfg_we,
  input  logic [mfqs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mfqs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [mfqs_pkg::STATUS_W-1:0]       out_status,
  output logic [mfqs_pkg::TASK_FIELD_W-1:0]   out_grant_task,
  output logic [mfqs_pkg::LEVEL_W-1:0]        out_grant_level,
  output logic [mfqs_pkg::SLICE_W-1:0]        out_grant_slice,
  output logic                                out_demoted,
  output logic                                out_removed
);
  import mfqs_pkg::*;

  // Captured item
  op_t      op_r;
  task_id_t task_r;
  logic     alive_r;

  // Scheduler state
  pos_t     head_r       [LEVEL_COUNT];
  pos_t     head_nxt     [LEVEL_COUNT];
  cnt_t     count_r      [LEVEL_COUNT];
  cnt_t     count_nxt    [LEVEL_COUNT];
  task_id_t held_task_r  [LEVEL_COUNT];
  task_id_t held_task_nxt[LEVEL_COUNT];
  logic     held_valid_r  [LEVEL_COUNT];
  logic     held_valid_nxt[LEVEL_COUNT];
  slice_t   slices_r     [LEVEL_COUNT];
  slice_t   slices_nxt   [LEVEL_COUNT];
  slice_t   limit_r      [LEVEL_COUNT];
  slice_t   limit_nxt    [LEVEL_COUNT];
  logic     grant_r;
  logic     grant_nxt;
  level_t   glv_r;
  level_t   glv_nxt;

  // Task store
  task_id_t mem [MEM_DEPTH];
  task_id_t rd_data_r;
  addr_t    rd_addr;
  logic     wr_en;
  addr_t    wr_addr;

  // Level search
  logic     found;
  logic     found_held;
  level_t   found_lv;

  // Result
  logic     out_valid_r;
  logic     out_valid_nxt;
  status_t  res_status,  out_status_r;
  task_id_t res_task,    out_task_r;
  level_t   res_level,   out_level_r;
  slice_t   res_slice,   out_slice_r;
  logic     res_demoted, out_demoted_r;
  logic     res_removed, out_removed_r;

  // Slice-done helpers
  slice_t   cur_slice;
  level_t   dest_lv;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      task_r  <= TASK_ID_BITS'(in_task_id);
      alive_r <= in_still_alive;
    end
  end

  // Find the first level with a held task or a queued one
  always_comb begin
    found      = 1'b0;
    found_held = 1'b0;
    found_lv   = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!found) begin
        if (held_valid_r[i]) begin
          found      = 1'b1;
          found_held = 1'b1;
          found_lv   = level_t'(i);
        end else if (count_r[i] != '0) begin
          found    = 1'b1;
          found_lv = level_t'(i);
        end
      end
    end
  end

  assign rd_addr         = slot_addr(found_lv, head_r[found_lv]);
  assign stat.pop_needed = (op_r == OP_DISPATCH) && !grant_r && found && !found_held;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign cur_slice = slice_t'(slices_r[glv_r] + 1'b1);
  assign dest_lv   = (glv_r == level_t'(BOTTOM_LEVEL)) ? glv_r : level_t'(glv_r + 1'b1);

  // Work out the next state and the result of the current item
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    held_task_nxt  = held_task_r;
    held_valid_nxt = held_valid_r;
    slices_nxt     = slices_r;
    grant_nxt      = grant_r;
    glv_nxt        = glv_r;
    wr_en          = 1'b0;
    wr_addr        = slot_addr('0, tail_pos(head_r[0], count_r[0]));
    res_status     = ST_OK;
    res_task       = '0;
    res_level      = '0;
    res_slice      = '0;
    res_demoted    = 1'b0;
    res_removed    = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (count_r[0] == CNT_W'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          count_nxt[0] = cnt_t'(count_r[0] + 1'b1);
        end
      end
      OP_DISPATCH: begin
        if (grant_r) begin
          res_task  = held_task_r[glv_r];
          res_level = glv_r;
          res_slice = cur_slice;
        end else if (!found) begin
          res_status = ST_EMPTY;
        end else begin
          grant_nxt = 1'b1;
          glv_nxt   = found_lv;
          res_level = found_lv;
          if (found_held) begin
            res_task  = held_task_r[found_lv];
            res_slice = slice_t'(slices_r[found_lv] + 1'b1);
          end else begin
            // pop the head into the held slot
            held_task_nxt[found_lv]  = rd_data_r;
            held_valid_nxt[found_lv] = 1'b1;
            slices_nxt[found_lv]     = '0;
            head_nxt[found_lv]       = next_pos(head_r[found_lv]);
            count_nxt[found_lv]      = cnt_t'(count_r[found_lv] - 1'b1);
            res_task                 = rd_data_r;
            res_slice                = slice_t'(1);
          end
        end
      end
      OP_SLICE_DONE: begin
        if (!grant_r) begin
          res_status = ST_NO_GRANT;
        end else begin
          grant_nxt = 1'b0;
          res_task  = held_task_r[glv_r];
          res_level = glv_r;
          res_slice = cur_slice;
          if (!alive_r) begin
            // drop the dead task
            held_valid_nxt[glv_r] = 1'b0;
            slices_nxt[glv_r]     = '0;
            res_removed           = 1'b1;
          end else if (cur_slice >= limit_r[glv_r]) begin
            // move the task on, one level down or back to the bottom
            slices_nxt[glv_r]     = '0;
            held_valid_nxt[glv_r] = 1'b0;
            wr_addr               = slot_addr(dest_lv, tail_pos(head_r[dest_lv],
                                                                count_r[dest_lv]));
            if (count_r[dest_lv] == CNT_W'(QUEUE_DEPTH)) begin
              res_status = ST_FULL;
            end else begin
              wr_en              = 1'b1;
              count_nxt[dest_lv] = cnt_t'(count_r[dest_lv] + 1'b1);
              res_demoted        = (dest_lv != glv_r);
            end
          end else begin
            slices_nxt[glv_r] = cur_slice;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Store write and registered head read
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= (op_r == OP_ADD) ? task_r : held_task_r[glv_r];
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Slice limit writes; indexes past the last level are ignored
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_we && (cfg_index == CFG_LEVEL0_LIMIT || cfg_index == CFG_LEVEL1_LIMIT ||
                   cfg_index == CFG_LEVEL2_LIMIT)) begin
      limit_nxt[cfg_index] = slice_t'(cfg_data);
    end
  end

  // Result register: take a new result or drop the one taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        head_r[i]       <= '0;
        count_r[i]      <= '0;
        held_valid_r[i] <= 1'b0;
        slices_r[i]     <= '0;
        limit_r[i]      <= LIMIT_RESET[i];
      end
      grant_r     <= 1'b0;
      glv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head_r       <= head_nxt;
        count_r      <= count_nxt;
        held_valid_r <= held_valid_nxt;
        slices_r     <= slices_nxt;
        grant_r      <= grant_nxt;
        glv_r        <= glv_nxt;
      end
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Held task ids and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      held_task_r   <= held_task_nxt;
      out_status_r  <= res_status;
      out_task_r    <= res_task;
      out_level_r   <= res_level;
      out_slice_r   <= res_slice;
      out_demoted_r <= res_demoted;
      out_removed_r <= res_removed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_grant_task  = TASK_FIELD_W'(out_task_r);
  assign out_grant_level = out_level_r;
  assign out_grant_slice = out_slice_r;
  assign out_demoted     = out_demoted_r;
  assign out_removed     = out_removed_r;

`include "multilevel_feedback_queue_scheduler_top_assert.svh"

  `MFQS_ASSERT(a_count_bound, (count_r[0] <= CNT_W'(QUEUE_DEPTH)) && (count_r[1] <= CNT_W'(QUEUE_DEPTH)) && (count_r[2] <= CNT_W'(QUEUE_DEPTH)), "fifo count above depth")
  `MFQS_ASSERT(a_grant_held, !grant_r || held_valid_r[glv_r], "grant without held task")
  `MFQS_ASSERT(a_slice_room, (slices_r[0] != '1) && (slices_r[1] != '1) && (slices_r[2] != '1), "slice count at top")

endmodule

/* sv/mfqs_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one item at a time: capture, decode, optional store read, commit.
// ----------------------------------------------------------------------------
module mfqs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfqs_pkg::dp_stat_t  stat,
  output mfqs_pkg::dp_cmd_t   cmd
);
  import mfqs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Issue commands from the current state
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.latch  = in_ready && in_valid;
  assign cmd.rd_en  = (state_r == S_DECODE) && stat.pop_needed;
  assign cmd.commit = (state_r == S_COMMIT) && stat.out_free;

  // Advance through the item
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = stat.pop_needed ? S_READ : S_COMMIT;
      end
      S_READ: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "multilevel_feedback_queue_scheduler_top_assert.svh"

  `MFQS_ASSERT_NEXT(a_accept_blocks, cmd.latch, !in_ready, "new item taken while one is in work")
  `MFQS_ASSERT_NEXT(a_read_then_wait, cmd.rd_en, (state_r == S_READ) && !cmd.commit, "commit before store read returned")
  `MFQS_ASSERT_NEXT(a_commit_frees, cmd.commit, in_ready, "controller busy after commit")

endmodule

/* sv/multilevel_feedback_queue_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler, top level
// Three-level task scheduler with per-level slice limits and held slots.
// ----------------------------------------------------------------------------
// Each item is handled on its own and returns exactly one result. An add, a
// slice-done report, a repeated dispatch, a dispatch that finds no task or a
// dispatch that resumes a held task runs through accept, decode and commit. A
// dispatch that pops a task from a level FIFO passes through a read state
// between decode and commit for the registered read of the shared 48-entry
// task store. The next item is accepted as soon as the previous result is
// loaded, even while that result still waits on out ready; a commit only
// stalls when the result register is still full.
// Slice limits are written through the cfg channel (index 0..2, index 3 is
// ignored) and are always ready; write them only while the block is idle.
// No clearing pass follows reset.
module multilevel_feedback_queue_scheduler_top (
  input  logic       clk,
  input  logic       rst_n,
  mfqs_in_if.sink    in_if,
  mfqs_out_if.source out_if,
  mfqs_cfg_if.sink   cfg_if
);
  import mfqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  // Sequencer
  mfqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queues, held slots and result register
  mfqs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_if.operation),
    .in_task_id      (in_if.task_id),
    .in_still_alive  (in_if.still_alive),
    .cfg_we          (cfg_if.valid),
    .cfg_index       (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_status      (out_if.status),
    .out_grant_task  (out_if.grant_task),
    .out_grant_level (out_if.grant_level),
    .out_grant_slice (out_if.grant_slice),
    .out_demoted     (out_if.demoted),
    .out_removed     (out_if.removed)
  );

endmodule
